### rtl/sgtr_pkg.sv
`timescale 1ns / 1ps

package sgtr_pkg;

   localparam int unsigned GLYPH_COLS    = 5;
   localparam int unsigned GLYPH_ROWS    = 7;
   localparam int unsigned GLYPH_CELLS   = GLYPH_COLS * GLYPH_ROWS;
   localparam int unsigned COORD_W       = 16;
   localparam int unsigned COLOR_W       = 16;
   localparam int unsigned SCALE_W       = 8;
   localparam int unsigned CODE_W        = 8;
   localparam int unsigned CSR_INDEX_W   = 8;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned ROW_CNT_W     = 3;
   localparam logic [CODE_W-1:0] CASE_FOLD = 8'd32;

   localparam logic [COLOR_W-1:0] FILL_COLOR_RESET  = 16'hFFFF;
   localparam logic [SCALE_W-1:0] GLYPH_SCALE_RESET = 8'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILL_COLOR  = 8'd0,
      CSR_GLYPH_SCALE = 8'd1
   } csr_index_type;

   typedef logic [GLYPH_CELLS-1:0] glyph_bits_type;

   // 35 cells, column 0 in the low seven bits, row 0 lowest within a column
   function automatic glyph_bits_type glyph_bits(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] folded;
      glyph_bits_type    bits;
      folded = code;
      if (code >= "a" && code <= "z") begin
         folded = code - CASE_FOLD;
      end
      case (folded)
         "0":     bits = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
         "1":     bits = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
         "2":     bits = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
         "3":     bits = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
         "4":     bits = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
         "5":     bits = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
         "6":     bits = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
         "7":     bits = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
         "8":     bits = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         "9":     bits = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
         "A":     bits = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
         "D":     bits = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h7F};
         "E":     bits = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
         "H":     bits = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
         "I":     bits = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
         "M":     bits = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
         "P":     bits = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
         "R":     bits = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
         "T":     bits = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
         "U":     bits = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
         "Y":     bits = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
         ".":     bits = {7'h00, 7'h00, 7'h60, 7'h00, 7'h00};
         "%":     bits = {7'h62, 7'h64, 7'h08, 7'h13, 7'h23};
         "C":     bits = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
         ":":     bits = {7'h00, 7'h00, 7'h36, 7'h00, 7'h00};
         default: bits = '0;  // space and unsupported codes are blank
      endcase
      return bits;
   endfunction

endpackage

### rtl/scaled_glyph_text_renderer_core.sv
`timescale 1ns / 1ps

// 5x7 text renderer: one character word in, one word out per lit glyph cell,
// each carrying the top-left corner of a square block of side glyph_scale and
// the fill colour; the final block of a character has last_block set.
// Characters are handled one at a time: the accept cycle reads the cursor
// from its one-entry memory, the next cycle builds the origin and writes the
// advanced cursor back, then the glyph is scanned one cell per cycle, column
// by column, rows ascending, stopping after the last lit cell; a lit cell
// waits while the output register still holds a block the result side has
// not taken. Blank, unsupported characters and a zero scale give no word
// and go from the cursor update straight back to idle. The cursor advances
// by six times the scale whether or not anything is drawn; restart_cursor
// reloads it first.
// Configuration writes are always ready and take effect at once.
module scaled_glyph_text_renderer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // character words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sgtr_pkg::CODE_W-1:0]          req_char_code,
   input  logic                                 req_restart_cursor,
   input  logic [sgtr_pkg::COORD_W-1:0]         req_start_x,
   input  logic [sgtr_pkg::COORD_W-1:0]         req_start_y,
   // block words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sgtr_pkg::COORD_W-1:0]         rsp_block_x,
   output logic [sgtr_pkg::COORD_W-1:0]         rsp_block_y,
   output logic [sgtr_pkg::COLOR_W-1:0]         rsp_block_color,
   output logic                                 rsp_last_block,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgtr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sgtr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   localparam int unsigned CURSOR_W = 2 * sgtr_pkg::COORD_W;
   localparam logic [sgtr_pkg::ROW_CNT_W-1:0] LAST_ROW =
      sgtr_pkg::ROW_CNT_W'(sgtr_pkg::GLYPH_ROWS - 1);

   state_type                          state_ff;

   // configuration
   logic [sgtr_pkg::COLOR_W-1:0]       fill_color_ff;
   logic [sgtr_pkg::SCALE_W-1:0]       glyph_scale_ff;

   // cursor store: {row, col}, one entry, registered read
   logic [CURSOR_W-1:0]                cursor_mem [1];
   logic [CURSOR_W-1:0]                cursor_rd_ff;
   logic                               cursor_valid_ff;

   // latched character word
   logic                               restart_ff;
   logic [sgtr_pkg::COORD_W-1:0]       start_x_ff;
   logic [sgtr_pkg::COORD_W-1:0]       start_y_ff;

   // scan state
   sgtr_pkg::glyph_bits_type           glyph_ff;
   logic [sgtr_pkg::ROW_CNT_W-1:0]     row_ff;
   logic [sgtr_pkg::COORD_W-1:0]       x_off_ff;
   logic [sgtr_pkg::COORD_W-1:0]       y_off_ff;
   logic [sgtr_pkg::COORD_W-1:0]       base_col_ff;
   logic [sgtr_pkg::COORD_W-1:0]       base_row_ff;

   // output register
   logic                               rsp_valid_ff;
   logic [sgtr_pkg::COORD_W-1:0]       block_x_ff;
   logic [sgtr_pkg::COORD_W-1:0]       block_y_ff;
   logic [sgtr_pkg::COLOR_W-1:0]       block_color_ff;
   logic                               last_block_ff;

   logic                               req_fire;
   logic                               csr_fire;
   logic                               out_free;
   logic                               scan_step;
   logic                               rest_empty;
   logic [sgtr_pkg::COORD_W-1:0]       scale_ext;
   logic [sgtr_pkg::COORD_W-1:0]       advance;
   logic [sgtr_pkg::COORD_W-1:0]       cur_col;
   logic [sgtr_pkg::COORD_W-1:0]       cur_row;
   sgtr_pkg::glyph_bits_type           glyph_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_x     = block_x_ff;
   assign rsp_block_y     = block_y_ff;
   assign rsp_block_color = block_color_ff;
   assign rsp_last_block  = last_block_ff;

   // output register can take a block this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // dark cells never stall, lit cells wait for the output register
   assign scan_step  = (state_ff == ST_SCAN) && (!glyph_ff[0] || out_free);
   assign rest_empty = (glyph_ff[sgtr_pkg::GLYPH_CELLS-1:1] == '0);

   assign scale_ext = sgtr_pkg::COORD_W'(glyph_scale_ff);
   // six cells of advance: 4*scale + 2*scale
   assign advance   = (scale_ext << 2) + (scale_ext << 1);

   // cursor as seen by this character; unwritten store reads as zero
   always_comb begin
      if (restart_ff) begin
         cur_col = start_x_ff;
         cur_row = start_y_ff;
      end else if (cursor_valid_ff) begin
         cur_col = cursor_rd_ff[sgtr_pkg::COORD_W-1:0];
         cur_row = cursor_rd_ff[CURSOR_W-1:sgtr_pkg::COORD_W];
      end else begin
         cur_col = '0;
         cur_row = '0;
      end
   end

   // zero scale draws nothing, so it simply gets an empty bitmap
   assign glyph_in = (glyph_scale_ff == '0) ? '0 : sgtr_pkg::glyph_bits(req_char_code);

   // cursor store: read every cycle, written back once per character
   always_ff @(posedge clock) begin
      cursor_rd_ff <= cursor_mem[0];
      if (state_ff == ST_READ) begin
         cursor_mem[0] <= {cur_row, cur_col + advance};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_color_ff   <= sgtr_pkg::FILL_COLOR_RESET;
         glyph_scale_ff  <= sgtr_pkg::GLYPH_SCALE_RESET;
         cursor_valid_ff <= 1'b0;
         glyph_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_fire) begin
            unique case (csr_index)
               sgtr_pkg::CSR_FILL_COLOR:  fill_color_ff <= csr_wdata;
               sgtr_pkg::CSR_GLYPH_SCALE: glyph_scale_ff <= csr_wdata[sgtr_pkg::SCALE_W-1:0];
               default: ;  // unknown index ignored
            endcase
         end

         // taken word leaves unless a new block replaces it
         if (rsp_valid_ff && rsp_ready && !(scan_step && glyph_ff[0])) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  restart_ff <= req_restart_cursor;
                  start_x_ff <= req_start_x;
                  start_y_ff <= req_start_y;
                  glyph_ff   <= glyph_in;
                  state_ff   <= ST_READ;
               end
            end
            ST_READ: begin
               // cursor data arrives now; origin fixed, store updated
               cursor_valid_ff <= 1'b1;
               base_col_ff     <= cur_col;
               base_row_ff     <= cur_row;
               row_ff          <= '0;
               x_off_ff        <= '0;
               y_off_ff        <= '0;
               state_ff        <= (glyph_ff == '0) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
               if (scan_step) begin
                  if (glyph_ff[0]) begin
                     rsp_valid_ff   <= 1'b1;
                     block_x_ff     <= base_col_ff + x_off_ff;
                     block_y_ff     <= base_row_ff + y_off_ff;
                     block_color_ff <= fill_color_ff;
                     last_block_ff  <= rest_empty;
                  end
                  glyph_ff <= glyph_ff >> 1;
                  if (row_ff == LAST_ROW) begin
                     // next column
                     row_ff   <= '0;
                     y_off_ff <= '0;
                     x_off_ff <= x_off_ff + scale_ext;
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     y_off_ff <= y_off_ff + scale_ext;
                  end
                  if (rest_empty) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a character always passes through the cursor read-modify-write state
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_READ))
      else $error("accepted character did not move to cursor update");

   // no cells are left over once the block is idle again
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (glyph_ff == '0))
      else $error("glyph cells left while idle");

   // the last lit cell ends the character and is flagged as such
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (scan_step && glyph_ff[0] && rest_empty) |=>
         ((state_ff == ST_IDLE) && rsp_valid_ff && last_block_ff))
      else $error("final block not flagged or scan did not end");

   a_scale_zero_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (glyph_scale_ff == '0)) |=> (glyph_ff == '0))
      else $error("zero scale loaded a non-empty glyph");

endmodule

### sim/tb_scaled_glyph_text_renderer_core.sv
`timescale 1ns / 1ps

// one drawn block as it leaves the renderer
typedef struct packed {
   logic [sgtr_pkg::COORD_W-1:0] x;
   logic [sgtr_pkg::COORD_W-1:0] y;
   logic [sgtr_pkg::COLOR_W-1:0] colour;
   logic                         last;
} block_word_type;

// five font columns, column 0 first, row 0 in bit 0
typedef logic [0:sgtr_pkg::GLYPH_COLS-1][7:0] glyph_columns_type;

// own copy of the cursor, the registers and the blocks still owed
class glyph_block_scoreboard;
   localparam int unsigned CURSOR_ADVANCE_CELLS = 6;
   localparam int          MAX_REPORTED         = 10;

   block_word_type               owed_blocks[$];
   logic [sgtr_pkg::COLOR_W-1:0] fill_colour;
   logic [sgtr_pkg::SCALE_W-1:0] cell_size;
   logic [sgtr_pkg::COORD_W-1:0] cursor_col;
   logic [sgtr_pkg::COORD_W-1:0] cursor_row;
   int                           failures;

   function new();
      fill_colour = sgtr_pkg::FILL_COLOR_RESET;
      cell_size   = sgtr_pkg::GLYPH_SCALE_RESET;
      cursor_col  = '0;
      cursor_row  = '0;
      failures    = 0;
   endfunction

   function glyph_columns_type font_columns(logic [sgtr_pkg::CODE_W-1:0] code);
      logic [sgtr_pkg::CODE_W-1:0] folded;
      folded = code;
      if (code >= "a" && code <= "z") begin
         folded = code - sgtr_pkg::CASE_FOLD;
      end
      case (folded)
         "0":     return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         "1":     return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         "2":     return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         "3":     return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         "4":     return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         "5":     return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         "6":     return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
         "7":     return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         "8":     return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         "9":     return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
         "A":     return {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         "D":     return {8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E};
         "E":     return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
         "H":     return {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         "I":     return {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         "M":     return {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         "P":     return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         "R":     return {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
         "T":     return {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         "U":     return {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         "Y":     return {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         ".":     return {8'h00, 8'h00, 8'h60, 8'h00, 8'h00};
         "%":     return {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
         "C":     return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
         ":":     return {8'h00, 8'h00, 8'h36, 8'h00, 8'h00};
         default: return '0;
      endcase
   endfunction

   function void set_register(logic [sgtr_pkg::CSR_INDEX_W-1:0] index,
                              logic [sgtr_pkg::CSR_DATA_W-1:0] data);
      case (index)
         sgtr_pkg::CSR_FILL_COLOR:  fill_colour = data[sgtr_pkg::COLOR_W-1:0];
         sgtr_pkg::CSR_GLYPH_SCALE: cell_size = data[sgtr_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endfunction

   // one accepted character: queue its blocks, then move the cursor on
   function void note_char(logic [sgtr_pkg::CODE_W-1:0] code, logic restart,
                           logic [sgtr_pkg::COORD_W-1:0] start_x,
                           logic [sgtr_pkg::COORD_W-1:0] start_y);
      glyph_columns_type cols;
      block_word_type    word;
      bit                held;
      int                col;
      int                row;
      held = 1'b0;
      word = '0;
      if (restart) begin
         cursor_col = start_x;
         cursor_row = start_y;
      end
      cols = font_columns(code);
      if (cell_size != 0) begin
         for (col = 0; col < sgtr_pkg::GLYPH_COLS; col++) begin
            for (row = 0; row < sgtr_pkg::GLYPH_ROWS; row++) begin
               if (cols[col][row]) begin
                  if (held) begin
                     owed_blocks.push_back(word);
                  end
                  word.x      = sgtr_pkg::COORD_W'(cursor_col + col * cell_size);
                  word.y      = sgtr_pkg::COORD_W'(cursor_row + row * cell_size);
                  word.colour = fill_colour;
                  word.last   = 1'b0;
                  held        = 1'b1;
               end
            end
         end
         if (held) begin
            word.last = 1'b1;
            owed_blocks.push_back(word);
         end
      end
      cursor_col = sgtr_pkg::COORD_W'(cursor_col + CURSOR_ADVANCE_CELLS * cell_size);
   endfunction

   function void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTED) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function void check_block(block_word_type got);
      block_word_type want;
      if (owed_blocks.size() == 0) begin
         note_failure($sformatf("block x=%h y=%h colour=%h last=%b with nothing owed",
                                got.x, got.y, got.colour, got.last));
         return;
      end
      want = owed_blocks.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour ||
          got.last !== want.last) begin
         note_failure($sformatf({"block mismatch: expected x=%h y=%h colour=%h last=%b, ",
                                 "got x=%h y=%h colour=%h last=%b"},
                                want.x, want.y, want.colour, want.last,
                                got.x, got.y, got.colour, got.last));
      end
   endfunction

   function int pending();
      return owed_blocks.size();
   endfunction

   function void check_drained();
      if (owed_blocks.size() != 0) begin
         note_failure($sformatf("%0d blocks never arrived", owed_blocks.size()));
      end
   endfunction
endclass

module tb_scaled_glyph_text_renderer_core;

   // settle time after the last owed block, so that a character that draws
   // nothing has also left the core
   localparam int SETTLE_CYCLES = 48;
   localparam int ITEMS_PER_SETTING = 50;
   // indexes that select no register
   localparam logic [sgtr_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 8'd2;
   localparam logic [sgtr_pkg::CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = 8'hFF;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [sgtr_pkg::CODE_W-1:0]      req_char_code;
   logic                             req_restart_cursor;
   logic [sgtr_pkg::COORD_W-1:0]     req_start_x;
   logic [sgtr_pkg::COORD_W-1:0]     req_start_y;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [sgtr_pkg::COORD_W-1:0]     rsp_block_x;
   logic [sgtr_pkg::COORD_W-1:0]     rsp_block_y;
   logic [sgtr_pkg::COLOR_W-1:0]     rsp_block_color;
   logic                             rsp_last_block;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [sgtr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sgtr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // chance in a hundred that a side idles in a given cycle
   int req_idle_pct = 25;
   int rsp_idle_pct = 25;

   // characters the font knows, letters in upper case
   string font_chars = "0123456789ADEHIMPRTUY. %C:";

   glyph_block_scoreboard owed;

   scaled_glyph_text_renderer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .req_restart_cursor (req_restart_cursor),
      .req_start_x        (req_start_x),
      .req_start_y        (req_start_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_block_x        (rsp_block_x),
      .rsp_block_y        (rsp_block_y),
      .rsp_block_color    (rsp_block_color),
      .rsp_last_block     (rsp_last_block),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // watch all three handshakes; values seen here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            owed.set_register(csr_index, csr_wdata);
         end
         if (rsp_valid && rsp_ready) begin
            owed.check_block({rsp_block_x, rsp_block_y, rsp_block_color, rsp_last_block});
         end
         if (req_valid && req_ready) begin
            owed.note_char(req_char_code, req_restart_cursor, req_start_x, req_start_y);
         end
      end
   end

   // valid stays high after acceptance so back-to-back words need no second
   // assignment in the same step; the next call, if it idles, or settle lowers it
   task automatic send_char(logic [sgtr_pkg::CODE_W-1:0] code, logic restart,
                            logic [sgtr_pkg::COORD_W-1:0] start_x,
                            logic [sgtr_pkg::COORD_W-1:0] start_y);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_char_code      <= code;
      req_restart_cursor <= restart;
      req_start_x        <= start_x;
      req_start_y        <= start_y;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_text(string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         send_char(text[i], 1'b0, 16'($urandom), 16'($urandom));
      end
   endtask

   // hold_valid keeps the channel up for a write that follows straight on
   task automatic write_register(logic [sgtr_pkg::CSR_INDEX_W-1:0] index,
                                 logic [sgtr_pkg::CSR_DATA_W-1:0] data, bit hold_valid);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (!hold_valid) begin
         csr_valid <= 1'b0;
      end
   endtask

   // stop sending, let every owed block out, then let a character that draws nothing finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [sgtr_pkg::CODE_W-1:0] random_char();
      logic [sgtr_pkg::CODE_W-1:0] code;
      if ($urandom_range(99) < 75) begin
         code = font_chars[$urandom_range(font_chars.len() - 1)];
         if (code >= "A" && code <= "Z" && $urandom_range(1) == 1) begin
            code = code + sgtr_pkg::CASE_FOLD;
         end
      end else begin
         code = sgtr_pkg::CODE_W'($urandom_range(255));
      end
      return code;
   endfunction

   // bias towards both ends of the coordinate range so wrapping is common
   function automatic logic [sgtr_pkg::COORD_W-1:0] random_coord();
      case ($urandom_range(3))
         0:       return sgtr_pkg::COORD_W'($urandom_range(16'hFFFF, 16'hF800));
         1:       return sgtr_pkg::COORD_W'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_random(int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_char(random_char(), ($urandom_range(3) == 0), random_coord(), random_coord());
      end
   endtask

   task automatic run_directed();
      // reset settings: unit scale, white, cursor at the origin
      // covers case folding, blank, unsupported and top-half codes
      send_text("0Aa %:.Cz");
      send_char(8'hFF, 1'b0, 16'h0000, 16'h0000);
      send_char(8'h80, 1'b0, 16'hFFFF, 16'hFFFF);
      send_char(8'h00, 1'b0, 16'h0000, 16'h0000);
      // cursor at the very top of the range, blocks wrap past zero
      send_char("8", 1'b1, 16'hFFFF, 16'hFFFF);
      send_char("M", 1'b1, 16'h0000, 16'h0000);
      settle();
      // largest cell, black
      write_register(sgtr_pkg::CSR_FILL_COLOR, 16'h0000, 1'b1);
      write_register(sgtr_pkg::CSR_GLYPH_SCALE, 16'h00FF, 1'b0);
      send_char("E", 1'b1, 16'hFFF0, 16'hFF00);
      send_text("H9W");
      settle();
      // zero cell draws nothing and leaves the cursor where it is
      write_register(sgtr_pkg::CSR_GLYPH_SCALE, 16'h0000, 1'b1);
      write_register(sgtr_pkg::CSR_FILL_COLOR, 16'hFFFF, 1'b0);
      send_char("8", 1'b0, 16'h0000, 16'h0000);
      send_char("4", 1'b1, 16'd100, 16'd200);
      settle();
      // writes to unused indexes must leave both registers alone
      write_register(sgtr_pkg::CSR_FILL_COLOR, 16'hA5A5, 1'b1);
      write_register(sgtr_pkg::CSR_GLYPH_SCALE, 16'h0003, 1'b1);
      write_register(CSR_FIRST_UNUSED, 16'h5A5A, 1'b1);
      write_register(CSR_LAST_UNUSED, 16'h0000, 1'b0);
      send_char("T", 1'b1, 16'd7, 16'd9);
      send_text("uyPRDI");
   endtask

   initial begin
      int phase;
      int setting;
      owed = new();
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_char_code      <= '0;
      req_restart_cursor <= 1'b0;
      req_start_x        <= '0;
      req_start_y        <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= sgtr_pkg::CSR_FILL_COLOR;
      csr_wdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // receiver then sender idling heavily, then no idling at all
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 33; rsp_idle_pct = 88; end
            1:       begin req_idle_pct = 88; rsp_idle_pct = 33; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         for (setting = 0; setting < 3; setting++) begin
            settle();
            case (setting)
               0: begin
                  write_register(sgtr_pkg::CSR_FILL_COLOR, 16'($urandom), 1'b1);
                  write_register(sgtr_pkg::CSR_GLYPH_SCALE, 16'($urandom_range(1, 3)), 1'b0);
               end
               1: begin
                  // extremes of both registers
                  write_register(sgtr_pkg::CSR_FILL_COLOR,
                                 (phase == 1) ? 16'hFFFF : 16'h0000, 1'b1);
                  write_register(sgtr_pkg::CSR_GLYPH_SCALE,
                                 (phase == 1) ? 16'h0000 : 16'h00FF, 1'b0);
               end
               default: begin
                  write_register(sgtr_pkg::CSR_INDEX_W'($urandom_range(CSR_LAST_UNUSED,
                                                                       CSR_FIRST_UNUSED)),
                                 16'($urandom), 1'b1);
                  write_register(sgtr_pkg::CSR_FILL_COLOR, 16'($urandom), 1'b1);
                  write_register(sgtr_pkg::CSR_GLYPH_SCALE, 16'($urandom), 1'b0);
               end
            endcase
            run_random(ITEMS_PER_SETTING);
         end
      end

      settle();
      owed.check_drained();
      if (owed.failures == 0) begin
         $display("scaled_glyph_text_renderer_core verification clean");
      end else begin
         $display("scaled_glyph_text_renderer_core verification failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("scaled_glyph_text_renderer_core verification failed");
      $finish;
   end

endmodule
